### rtl/ucdp_pkg.sv
// ----------------------------------------------------------------------------
// ucdp_pkg
// Shared types and constants for the USB configuration descriptor parser:
// record kinds, the result record and the record pair the parser hands on.
// ----------------------------------------------------------------------------
package ucdp_pkg;

	// Default number of endpoint table slots; slot 0 is never used.
	localparam int ENDPOINT_SLOTS_DEF = 32;

	// Length of the configuration descriptor header in bytes.
	localparam int HEADER_LEN = 9;

	// Descriptor type codes that produce records.
	localparam logic [7:0] TYPE_INTERFACE = 8'd4;
	localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;

	// Depth of the result queue; it must hold two results beyond one in flight.
	localparam int QUEUE_DEPTH = 4;

	// Kind of a result record.
	typedef enum logic [1:0] {
		KIND_INTERFACE = 2'd0,
		KIND_ENDPOINT  = 2'd1,
		KIND_DONE      = 2'd2
	} kind_t;

	// One result record as it leaves the block.
	typedef struct packed {
		kind_t       kind;
		logic [4:0]  slot;
		logic [7:0]  class_code;
		logic [7:0]  subclass_code;
		logic [7:0]  ep_address;
		logic [7:0]  ep_attributes;
		logic [15:0] ep_max_packet;
		logic [7:0]  ep_interval;
		logic        status;
		logic [7:0]  config_value;
		logic [4:0]  endpoint_count;
		logic        is_last;
	} rec_t;

	// Up to two records caused by one byte, first in r0.
	typedef struct packed {
		logic [1:0] num;
		rec_t       r0;
		rec_t       r1;
	} rec_pair_t;

endpackage

### rtl/ucdp_parser.sv
// ----------------------------------------------------------------------------
// ucdp_parser
// Parser state and record generation. On each step it consumes one byte,
// updates the header capture and descriptor walk, and presents the records
// that byte causes.
// ----------------------------------------------------------------------------
module ucdp_parser #(
	parameter int ENDPOINT_SLOTS = ucdp_pkg::ENDPOINT_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output ucdp_pkg::rec_pair_t  recs
);

	localparam int SLOT_W = $clog2(ENDPOINT_SLOTS + 1);

	logic [15:0]       byte_position_q;
	logic [15:0]       declared_total_q;
	logic [7:0]        config_value_q;
	logic [7:0]        desc_length_q;
	logic [7:0]        desc_type_q;
	logic [7:0]        desc_offset_q;
	logic [47:0]       capture_q;
	logic              stopped_q;
	logic [SLOT_W-1:0] next_slot_q;

	logic [15:0]       pos_n;
	logic [15:0]       total_n;
	logic [7:0]        cfg_n;
	logic [7:0]        len_n;
	logic [7:0]        type_n;
	logic [7:0]        off_n;
	logic [47:0]       cap_n;
	logic              stop_n;
	logic [SLOT_W-1:0] slot_n;
	logic              walking;
	logic              complete;
	logic              desc_rec;
	ucdp_pkg::rec_t    drec;
	ucdp_pkg::rec_t    done_rec;
	logic              short_block;
	logic [31:0]       slot_wide;
	logic [31:0]       count_wide;

	// Next state of the header capture and the descriptor walk.
	always_comb begin
		total_n   = declared_total_q;
		cfg_n     = config_value_q;
		len_n     = desc_length_q;
		type_n    = desc_type_q;
		off_n     = desc_offset_q;
		cap_n     = capture_q;
		stop_n    = stopped_q;
		slot_n    = next_slot_q;
		complete  = 1'b0;
		desc_rec  = 1'b0;
		drec      = '0;
		slot_wide = 32'(next_slot_q);

		if (byte_position_q == 16'd2) begin
			total_n[7:0] = data_byte;
		end else if (byte_position_q == 16'd3) begin
			total_n[15:8] = data_byte;
		end else if (byte_position_q == 16'd5) begin
			cfg_n = data_byte;
		end

		walking = (byte_position_q >= 16'(ucdp_pkg::HEADER_LEN)) &&
			(byte_position_q < declared_total_q) && !stopped_q;

		if (walking) begin
			if (desc_offset_q == 8'd0) begin
				// A descriptor starts: its length byte.
				if ((data_byte == 8'd0) ||
					(({1'b0, byte_position_q} + {9'd0, data_byte}) >
					{1'b0, declared_total_q})) begin
					stop_n = 1'b1;
				end else begin
					len_n  = data_byte;
					type_n = 8'd0;
					cap_n  = '0;
					if (data_byte == 8'd1) begin
						complete = 1'b1;
					end else begin
						off_n = 8'd1;
					end
				end
			end else begin
				// Type byte, then the field bytes at offsets two to seven.
				if (desc_offset_q == 8'd1) begin
					type_n = data_byte;
				end
				for (int i = 0; i < 6; i++) begin
					if (desc_offset_q == 8'(i + 2)) begin
						cap_n[i*8 +: 8] = data_byte;
					end
				end
				if (({1'b0, desc_offset_q} + 9'd1) >= {1'b0, desc_length_q}) begin
					complete = 1'b1;
					off_n    = 8'd0;
				end else begin
					off_n = desc_offset_q + 8'd1;
				end
			end
		end

		// Record for a completed interface or endpoint descriptor.
		if (complete) begin
			if (type_n == ucdp_pkg::TYPE_INTERFACE) begin
				desc_rec           = 1'b1;
				drec.kind          = ucdp_pkg::KIND_INTERFACE;
				drec.class_code    = cap_n[31:24];
				drec.subclass_code = cap_n[39:32];
				drec.is_last       = !last_byte;
			end else if ((type_n == ucdp_pkg::TYPE_ENDPOINT) &&
				(slot_wide < 32'(ENDPOINT_SLOTS))) begin
				desc_rec           = 1'b1;
				drec.kind          = ucdp_pkg::KIND_ENDPOINT;
				drec.slot          = slot_wide[4:0];
				drec.ep_address    = cap_n[7:0];
				drec.ep_attributes = cap_n[15:8];
				drec.ep_max_packet = cap_n[31:16];
				drec.ep_interval   = cap_n[39:32];
				drec.is_last       = !last_byte;
				slot_n             = next_slot_q + SLOT_W'(1);
			end
		end

		if (byte_position_q != 16'hFFFF) begin
			pos_n = byte_position_q + 16'd1;
		end else begin
			pos_n = byte_position_q;
		end
	end

	// Done record on the marked last byte.
	always_comb begin
		count_wide              = 32'(slot_n) - 32'd1;
		short_block             = pos_n < 16'(ucdp_pkg::HEADER_LEN);
		done_rec                = '0;
		done_rec.kind           = ucdp_pkg::KIND_DONE;
		done_rec.status         = short_block;
		done_rec.config_value   = short_block ? 8'd0 : cfg_n;
		done_rec.endpoint_count = count_wide[4:0];
		done_rec.is_last        = 1'b1;
	end

	// Order the records: descriptor record first, done record after it.
	always_comb begin
		recs    = '0;
		recs.r0 = desc_rec ? drec : done_rec;
		recs.r1 = done_rec;
		if (desc_rec && last_byte) begin
			recs.num = 2'd2;
		end else if (desc_rec || last_byte) begin
			recs.num = 2'd1;
		end else begin
			recs.num = 2'd0;
		end
	end

	// State registers; the last byte of a block returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			declared_total_q <= '0;
			config_value_q   <= '0;
			desc_length_q    <= '0;
			desc_type_q      <= '0;
			desc_offset_q    <= '0;
			capture_q        <= '0;
			stopped_q        <= 1'b0;
			next_slot_q      <= SLOT_W'(1);
		end else if (step) begin
			if (last_byte) begin
				byte_position_q  <= '0;
				declared_total_q <= '0;
				config_value_q   <= '0;
				desc_length_q    <= '0;
				desc_type_q      <= '0;
				desc_offset_q    <= '0;
				capture_q        <= '0;
				stopped_q        <= 1'b0;
				next_slot_q      <= SLOT_W'(1);
			end else begin
				byte_position_q  <= pos_n;
				declared_total_q <= total_n;
				config_value_q   <= cfg_n;
				desc_length_q    <= len_n;
				desc_type_q      <= type_n;
				desc_offset_q    <= off_n;
				capture_q        <= cap_n;
				stopped_q        <= stop_n;
				next_slot_q      <= slot_n;
			end
		end
	end

	// The slot counter stays within the table.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(next_slot_q) >= 32'd1) && (32'(next_slot_q) <= 32'(ENDPOINT_SLOTS)))
		else $error("endpoint slot counter out of range");

	// Inside a descriptor the offset never reaches its length.
	a_offset_in_desc: assert property (@(posedge clk) disable iff (!arst_n)
		(desc_offset_q != 8'd0) |-> (desc_offset_q < desc_length_q))
		else $error("descriptor offset past its length");

endmodule

### rtl/ucdp_out_queue.sv
// ----------------------------------------------------------------------------
// ucdp_out_queue
// Small result queue. Takes up to two records per cycle and hands them out
// one per cycle, while out_stall is low, on the valid/stall output channel.
// ----------------------------------------------------------------------------
module ucdp_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  ucdp_pkg::rec_pair_t push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output ucdp_pkg::rec_t      out_rec
);

	localparam int PTR_W = $clog2(ucdp_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(ucdp_pkg::QUEUE_DEPTH + 1);

	ucdp_pkg::rec_t   mem_q [ucdp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	// There is room when two more records fit.
	assign room      = count_q <= CNT_W'(ucdp_pkg::QUEUE_DEPTH - 2);
	assign out_valid = count_q != '0;
	assign out_rec   = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	// Record storage.
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.num) - CNT_W'(pop);
		end
	end

	// The fill count never exceeds the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ucdp_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	// Records are only pushed while there is room for a pair.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num != 2'd0) |-> room)
		else $error("records pushed without room");

endmodule

### rtl/usb_config_descriptor_parser_core.sv
// ----------------------------------------------------------------------------
// usb_config_descriptor_parser_core
// Parses a USB configuration descriptor block byte by byte and emits
// interface, endpoint and done records.
// ----------------------------------------------------------------------------
// The block accepts one byte per clock cycle while in_stall is low. A byte
// is held in an input register, parsed there, and the records it causes
// (none, one, or a descriptor record followed by the done record) go to a
// four-entry result queue that delivers one record per cycle while out_stall
// is low, so a result passes the input register and then the queue. The
// input stalls only while the queue cannot take two more records, which
// happens when the output side stalls; the queue's single read port sets
// the output rate of one record per cycle.
module usb_config_descriptor_parser_core #(
	parameter int ENDPOINT_SLOTS = ucdp_pkg::ENDPOINT_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [4:0]  slot,
	output logic [7:0]  class_code,
	output logic [7:0]  subclass_code,
	output logic [7:0]  ep_address,
	output logic [7:0]  ep_attributes,
	output logic [15:0] ep_max_packet,
	output logic [7:0]  ep_interval,
	output logic        status,
	output logic [7:0]  config_value,
	output logic [4:0]  endpoint_count,
	output logic        is_last
);

	logic                valid_s1;
	logic [7:0]          data_s1;
	logic                last_s1;
	logic                room;
	logic                step;
	ucdp_pkg::rec_pair_t recs;
	ucdp_pkg::rec_pair_t push;
	ucdp_pkg::rec_t      out_rec;

	// The held byte moves on when the queue has room for two records.
	assign step     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ucdp_parser #(
		.ENDPOINT_SLOTS(ENDPOINT_SLOTS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.recs      (recs)
	);

	// Only a byte that actually moves on pushes its records.
	always_comb begin
		push = recs;
		if (!step) begin
			push.num = 2'd0;
		end
	end

	ucdp_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rec   (out_rec)
	);

	// Result fields.
	assign kind           = out_rec.kind;
	assign slot           = out_rec.slot;
	assign class_code     = out_rec.class_code;
	assign subclass_code  = out_rec.subclass_code;
	assign ep_address     = out_rec.ep_address;
	assign ep_attributes  = out_rec.ep_attributes;
	assign ep_max_packet  = out_rec.ep_max_packet;
	assign ep_interval    = out_rec.ep_interval;
	assign status         = out_rec.status;
	assign config_value   = out_rec.config_value;
	assign endpoint_count = out_rec.endpoint_count;
	assign is_last        = out_rec.is_last;

endmodule

### bench/ucdp_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucdp_record_checker
// Watches both channels of the configuration descriptor parser. Every
// accepted byte runs through a behavioral copy of the parser, and the records
// it should cause are queued. Every accepted record is compared with the
// oldest queued one, over all its fields at once.
// ----------------------------------------------------------------------------
module ucdp_record_checker #(
	parameter int ENDPOINT_SLOTS = ucdp_pkg::ENDPOINT_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [4:0]  slot,
	input  logic [7:0]  class_code,
	input  logic [7:0]  subclass_code,
	input  logic [7:0]  ep_address,
	input  logic [7:0]  ep_attributes,
	input  logic [15:0] ep_max_packet,
	input  logic [7:0]  ep_interval,
	input  logic        status,
	input  logic [7:0]  config_value,
	input  logic [4:0]  endpoint_count,
	input  logic        is_last,
	output int          error_count,
	output int          pending_count
);

	// Parser state as the block should hold it.
	logic [15:0] byte_pos;
	logic [15:0] total_len;
	logic [7:0]  cfg_value;
	logic [7:0]  desc_len;
	logic [7:0]  walk_type;
	logic [7:0]  desc_off;
	logic [47:0] capture;
	logic        walk_done;
	logic [5:0]  free_slot;

	// Records still owed by the block, oldest first.
	ucdp_pkg::rec_t records_due[$];
	ucdp_pkg::rec_t got;
	ucdp_pkg::rec_t want;
	int             report_count;

	// Return to the state of a fresh block.
	task clear_walk();
		byte_pos  = '0;
		total_len = '0;
		cfg_value = '0;
		desc_len  = '0;
		walk_type = '0;
		desc_off  = '0;
		capture   = '0;
		walk_done = 1'b0;
		free_slot = 6'd1;
	endtask

	function string rec_text(ucdp_pkg::rec_t r);
		return {$sformatf("kind=%0d slot=%0d class=%02h sub=%02h addr=%02h attr=%02h ",
			r.kind, r.slot, r.class_code, r.subclass_code, r.ep_address,
			r.ep_attributes),
			$sformatf("mps=%04h ival=%02h st=%0d cfg=%02h eps=%0d last=%0d",
			r.ep_max_packet, r.ep_interval, r.status, r.config_value,
			r.endpoint_count, r.is_last)};
	endfunction

	// Advance the parser by one byte and queue the records it causes.
	task parse_byte(input logic [7:0] b, input logic lastb);
		int             pos;
		int             off;
		bit             complete;
		bit             have_rec;
		ucdp_pkg::rec_t rec;
		ucdp_pkg::rec_t done_rec;
		pos = byte_pos;
		complete = 1'b0;
		have_rec = 1'b0;
		rec = '0;

		// Header fields: total length and configuration value.
		if (pos == 2)
			total_len[7:0] = b;
		else if (pos == 3)
			total_len[15:8] = b;
		else if (pos == 5)
			cfg_value = b;

		// Walk the descriptor chain inside the declared total.
		if (pos >= ucdp_pkg::HEADER_LEN && pos < total_len && !walk_done) begin
			off = desc_off;
			if (off == 0) begin
				if (b == 8'd0 || pos + b > total_len) begin
					walk_done = 1'b1;
				end else begin
					desc_len = b;
					walk_type = '0;
					capture = '0;
					if (b == 8'd1)
						complete = 1'b1;
					else
						desc_off = 8'd1;
				end
			end else begin
				if (off == 1)
					walk_type = b;
				else if (off <= 7)
					capture[(off - 2) * 8 +: 8] = b;
				if (off + 1 >= desc_len) begin
					complete = 1'b1;
					desc_off = '0;
				end else begin
					desc_off = desc_off + 8'd1;
				end
			end

			// A finished interface or endpoint descriptor yields a record.
			if (complete) begin
				if (walk_type == ucdp_pkg::TYPE_INTERFACE) begin
					rec.kind = ucdp_pkg::KIND_INTERFACE;
					rec.class_code = capture[31:24];
					rec.subclass_code = capture[39:32];
					have_rec = 1'b1;
				end else if (walk_type == ucdp_pkg::TYPE_ENDPOINT &&
					free_slot < ENDPOINT_SLOTS) begin
					rec.kind = ucdp_pkg::KIND_ENDPOINT;
					rec.slot = free_slot[4:0];
					rec.ep_address = capture[7:0];
					rec.ep_attributes = capture[15:8];
					rec.ep_max_packet = capture[31:16];
					rec.ep_interval = capture[39:32];
					free_slot = free_slot + 6'd1;
					have_rec = 1'b1;
				end
			end
		end

		if (byte_pos != 16'hFFFF)
			byte_pos = byte_pos + 16'd1;

		if (have_rec) begin
			rec.is_last = !lastb;
			records_due.push_back(rec);
		end

		// The marked byte closes the block with a done record.
		if (lastb) begin
			done_rec = '0;
			done_rec.kind = ucdp_pkg::KIND_DONE;
			done_rec.status = (byte_pos < ucdp_pkg::HEADER_LEN);
			done_rec.config_value = done_rec.status ? 8'd0 : cfg_value;
			done_rec.endpoint_count = 5'(free_slot - 6'd1);
			done_rec.is_last = 1'b1;
			records_due.push_back(done_rec);
			clear_walk();
		end
	endtask

	initial begin
		error_count = 0;
		pending_count = 0;
		report_count = 0;
		clear_walk();
	end

	// Compare outgoing records first; a record never belongs to a byte taken
	// at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.kind = ucdp_pkg::kind_t'(kind);
				got.slot = slot;
				got.class_code = class_code;
				got.subclass_code = subclass_code;
				got.ep_address = ep_address;
				got.ep_attributes = ep_attributes;
				got.ep_max_packet = ep_max_packet;
				got.ep_interval = ep_interval;
				got.status = status;
				got.config_value = config_value;
				got.endpoint_count = endpoint_count;
				got.is_last = is_last;
				if (records_due.size() == 0) begin
					error_count++;
					if (report_count < 10)
						$display("unexpected record: %s", rec_text(got));
					report_count++;
				end else begin
					want = records_due.pop_front();
					if (got !== want) begin
						error_count++;
						if (report_count < 10) begin
							$display("mismatch: expected %s", rec_text(want));
							$display("          actual   %s", rec_text(got));
						end
						report_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				parse_byte(data_byte, last_byte);
			pending_count = records_due.size();
		end
	end

endmodule

### bench/tb_usb_config_descriptor_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_config_descriptor_parser_core
// Feeds the descriptor parser whole configuration blocks: directed blocks for
// the corner cases, then random blocks that are mostly well formed, with some
// noise. Both sides idle at random; the checker beside the block predicts
// and compares every record.
// ----------------------------------------------------------------------------
module tb_usb_config_descriptor_parser_core;

	localparam logic [7:0] TYPE_CONFIG  = 8'd2;
	localparam logic [7:0] TYPE_CS_IF   = 8'h24;
	localparam int         EP_DESC_LEN  = 7;
	localparam int         IF_DESC_LEN  = 9;
	localparam int         NO_PATCH     = -1;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         RANDOM_BYTES = 500;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [4:0]  slot;
	logic [7:0]  class_code;
	logic [7:0]  subclass_code;
	logic [7:0]  ep_address;
	logic [7:0]  ep_attributes;
	logic [15:0] ep_max_packet;
	logic [7:0]  ep_interval;
	logic        status;
	logic [7:0]  config_value;
	logic [4:0]  endpoint_count;
	logic        is_last;
	int          error_count;
	int          pending_count;

	// Bytes of the block being assembled.
	logic [7:0] block_q[$];
	bit         sender_steady;
	bit         receiver_steady;
	bit         hold_request;
	int         hold_left;
	int         shaped_bytes;
	int         block_index;

	usb_config_descriptor_parser_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .slot(slot), .class_code(class_code),
		.subclass_code(subclass_code), .ep_address(ep_address),
		.ep_attributes(ep_attributes), .ep_max_packet(ep_max_packet),
		.ep_interval(ep_interval), .status(status), .config_value(config_value),
		.endpoint_count(endpoint_count), .is_last(is_last)
	);

	ucdp_record_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .slot(slot), .class_code(class_code),
		.subclass_code(subclass_code), .ep_address(ep_address),
		.ep_attributes(ep_attributes), .ep_max_packet(ep_max_packet),
		.ep_interval(ep_interval), .status(status), .config_value(config_value),
		.endpoint_count(endpoint_count), .is_last(is_last),
		.error_count(error_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#100_000_000;
		$display("status: fail");
		$finish;
	end

	// Interface descriptor bytes at offsets 2..7, offset 2 in the low byte.
	function logic [47:0] iface_fields(input logic [7:0] cls, input logic [7:0] sub);
		return {8'($urandom), sub, cls, 8'($urandom), 8'($urandom), 8'($urandom)};
	endfunction

	// Endpoint descriptor bytes at offsets 2..7.
	function logic [47:0] ep_fields(input logic [7:0] addr, input logic [7:0] attr,
			input logic [15:0] mps, input logic [7:0] ival);
		return {8'($urandom), ival, mps, attr, addr};
	endfunction

	function logic [47:0] random_ep();
		return ep_fields(8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
	endfunction

	// Append one descriptor; bytes past offset 7 are random filler.
	task push_desc(input int len, input logic [7:0] dtype, input logic [47:0] fields);
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				block_q.push_back(8'(len));
			else if (i == 1)
				block_q.push_back(dtype);
			else if (i <= 7)
				block_q.push_back(fields[(i - 2) * 8 +: 8]);
			else
				block_q.push_back(8'($urandom));
		end
	endtask

	// Configuration header; the total length is filled in when sent.
	task push_header(input logic [7:0] cfg);
		block_q.push_back(8'(ucdp_pkg::HEADER_LEN));
		block_q.push_back(TYPE_CONFIG);
		block_q.push_back(8'd0);
		block_q.push_back(8'd0);
		block_q.push_back(8'($urandom));
		block_q.push_back(cfg);
		repeat (3) block_q.push_back(8'($urandom));
	endtask

	// One request on the input channel, with random idle cycles ahead of it.
	task send_byte(input logic [7:0] b, input logic lastb);
		while (!sender_steady && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= lastb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Patch the total length into the header and send the whole block.
	task send_block(input int total);
		if (total >= 0 && block_q.size() >= 4) begin
			block_q[2] = total[7:0];
			block_q[3] = total[15:8];
		end
		foreach (block_q[i])
			send_byte(block_q[i], i == block_q.size() - 1);
		block_q.delete();
	endtask

	task send_random_block();
		int pick;
		int len;
		int full;
		int total;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode == 7) begin
			// Raw noise: no header shaping at all.
			len = $urandom_range(1, 40);
			repeat (len) block_q.push_back(8'($urandom));
			send_block(NO_PATCH);
		end else if (mode == 8) begin
			// Block shorter than a header.
			len = $urandom_range(1, ucdp_pkg::HEADER_LEN - 1);
			repeat (len) block_q.push_back(8'($urandom));
			shaped_bytes += len;
			send_block(NO_PATCH);
		end else if (mode == 9) begin
			// Enough endpoints to run the table out, often.
			push_header(8'($urandom));
			repeat ($urandom_range(20, 40))
				push_desc(EP_DESC_LEN, ucdp_pkg::TYPE_ENDPOINT, random_ep());
			shaped_bytes += block_q.size();
			send_block(block_q.size());
		end else begin
			push_header(8'($urandom));
			repeat ($urandom_range(0, 8)) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : EP_DESC_LEN;
					push_desc(len, ucdp_pkg::TYPE_ENDPOINT, random_ep());
				end else if (pick < 70) begin
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : IF_DESC_LEN;
					push_desc(len, ucdp_pkg::TYPE_INTERFACE,
						iface_fields(8'($urandom), 8'($urandom)));
				end else if (pick < 95) begin
					push_desc($urandom_range(1, 20), 8'($urandom),
						48'({$urandom, $urandom}));
				end else begin
					block_q.push_back(8'd0);
				end
			end
			full = block_q.size();
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				total = full;
			end else if (pick < 75) begin
				total = full - $urandom_range(1, 12);
			end else if (pick < 85) begin
				total = full + $urandom_range(1, 12);
			end else begin
				// Stream ends inside the last descriptor.
				total = full;
				repeat ($urandom_range(1, 6))
					if (block_q.size() > 1)
						void'(block_q.pop_back());
			end
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 10)) block_q.push_back(8'($urandom));
			shaped_bytes += block_q.size();
			send_block(total);
		end
	endtask

	// Result side: random stalls, a long hold-off on request.
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !receiver_steady && ($urandom_range(99) < 20);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int total;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'd0;
		last_byte = 1'b0;
		sender_steady = 1'b0;
		receiver_steady = 1'b0;
		hold_request = 1'b0;
		shaped_bytes = 0;
		block_index = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Short blocks: one byte, up to the config value, one byte shy.
		block_q.push_back(8'hFF);
		send_block(NO_PATCH);
		repeat (6) block_q.push_back(8'hA5);
		send_block(NO_PATCH);
		repeat (8) block_q.push_back(8'($urandom));
		send_block(NO_PATCH);

		// Header alone, and a zero total that hides what follows.
		push_header(8'hFF);
		send_block(ucdp_pkg::HEADER_LEN);
		push_header(8'h00);
		push_desc(IF_DESC_LEN, ucdp_pkg::TYPE_INTERFACE, iface_fields(8'h03, 8'h01));
		send_block(0);

		// Field extremes; the final byte completes a record and the block.
		push_header(8'h01);
		push_desc(IF_DESC_LEN, ucdp_pkg::TYPE_INTERFACE, iface_fields(8'hFF, 8'h00));
		push_desc(EP_DESC_LEN, ucdp_pkg::TYPE_ENDPOINT,
			ep_fields(8'h81, 8'h03, 16'hFFFF, 8'hFF));
		push_desc(EP_DESC_LEN, ucdp_pkg::TYPE_ENDPOINT,
			ep_fields(8'h00, 8'h00, 16'h0000, 8'h00));
		push_desc(5, TYPE_CS_IF, 48'({$urandom, $urandom}));
		push_desc(4, 8'hFF, 48'({$urandom, $urandom}));
		push_desc(4, 8'h00, 48'({$urandom, $urandom}));
		push_desc(IF_DESC_LEN, ucdp_pkg::TYPE_INTERFACE, iface_fields(8'h00, 8'hFF));
		send_block(block_q.size());

		// A zero length stops the walk.
		push_header(8'h02);
		push_desc(IF_DESC_LEN, ucdp_pkg::TYPE_INTERFACE, iface_fields(8'h08, 8'h06));
		block_q.push_back(8'd0);
		push_desc(EP_DESC_LEN, ucdp_pkg::TYPE_ENDPOINT, random_ep());
		send_block(block_q.size());

		// A descriptor reaching past the declared total stops the walk.
		push_header(8'h03);
		push_desc(EP_DESC_LEN, ucdp_pkg::TYPE_ENDPOINT, random_ep());
		push_desc(EP_DESC_LEN, ucdp_pkg::TYPE_ENDPOINT, random_ep());
		send_block(block_q.size() - 3);

		// Stream ends inside an endpoint descriptor.
		push_header(8'h04);
		push_desc(IF_DESC_LEN, ucdp_pkg::TYPE_INTERFACE, iface_fields(8'h0E, 8'h02));
		push_desc(EP_DESC_LEN, ucdp_pkg::TYPE_ENDPOINT, random_ep());
		total = block_q.size();
		repeat (3) void'(block_q.pop_back());
		send_block(total);

		// One-byte descriptors, short descriptors and two maximum-length ones.
		push_header(8'h05);
		repeat (3) push_desc(1, 8'h00, '0);
		push_desc(6, ucdp_pkg::TYPE_INTERFACE, iface_fields(8'h0A, 8'h55));
		push_desc(4, ucdp_pkg::TYPE_ENDPOINT, ep_fields(8'h02, 8'h02, 16'h0200, 8'h01));
		push_desc(2, ucdp_pkg::TYPE_ENDPOINT, random_ep());
		push_desc(255, ucdp_pkg::TYPE_ENDPOINT, random_ep());
		push_desc(255, ucdp_pkg::TYPE_INTERFACE, iface_fields(8'hFE, 8'h01));
		send_block(block_q.size());

		// Bytes beyond the declared total are ignored.
		push_header(8'h06);
		push_desc(IF_DESC_LEN, ucdp_pkg::TYPE_INTERFACE, iface_fields(8'h01, 8'h01));
		total = block_q.size();
		push_desc(EP_DESC_LEN, ucdp_pkg::TYPE_ENDPOINT, random_ep());
		repeat (13) block_q.push_back(8'($urandom));
		send_block(total);

		// Table full, while the result side holds off so the input backs up.
		push_header(8'h07);
		repeat (35) push_desc(EP_DESC_LEN, ucdp_pkg::TYPE_ENDPOINT, random_ep());
		hold_request = 1'b1;
		send_block(block_q.size());

		// Random blocks, with one stretch where neither side idles.
		while (shaped_bytes < RANDOM_BYTES) begin
			sender_steady = (block_index >= 2 && block_index < 6);
			receiver_steady = sender_steady;
			send_random_block();
			block_index++;
		end
		sender_steady = 1'b0;
		receiver_steady = 1'b0;
		in_valid <= 1'b0;

		// Drain, then allow for anything late.
		wait (pending_count == 0);
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
